// ===== design/prfl_pkg.sv =====
// Package: page status codes, action codes, result codes and shared widths.
package prfl_pkg;
  localparam int unsigned NumPages = 1024;
  localparam int unsigned PageW    = $clog2(NumPages);
  localparam int unsigned CountW   = PageW + 1;
  localparam int unsigned TxW      = 32;

  localparam logic [1:0] StUsed = 2'd0;
  localparam logic [1:0] StFree = 2'd1;
  localparam logic [1:0] StPend = 2'd2;

  localparam logic [2:0] ActAlloc    = 3'd0;
  localparam logic [2:0] ActFree     = 3'd1;
  localparam logic [2:0] ActRelease  = 3'd2;
  localparam logic [2:0] ActRollback = 3'd3;
  localparam logic [2:0] ActClear    = 3'd4;
  localparam logic [2:0] ActLoad     = 3'd5;
  localparam logic [2:0] ActResetAll = 3'd6;
  localparam logic [2:0] ActUnused   = 3'd7;

  localparam logic [1:0] RsOk      = 2'd0;
  localparam logic [1:0] RsNoRun   = 2'd1;
  localparam logic [1:0] RsDouble  = 2'd2;
  localparam logic [1:0] RsLowPage = 2'd3;

  // Command broadcast to every cell during one pass.
  typedef struct packed {
    logic [2:0]       op;
    logic [PageW-1:0] lo;
    logic [PageW:0]   hi;     // exclusive upper bound of a page range
    logic [TxW-1:0]   tx;
    logic             apply;  // commit pass (vs. check pass)
  } cell_cmd_t;

  // Per-cell response.
  typedef struct packed {
    logic is_free;
    logic hit;      // page would change under the command (never set by clear or reset-all)
    logic bad;      // free check: page not in use
  } cell_rsp_t;
endpackage

// ===== design/prfl_cell.sv =====
// One page cell: holds the page status and its pending transaction.
module prfl_cell
  import prfl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PageW-1:0] idx_i,
  input  logic             en_i,
  input  cell_cmd_t        cmd_i,
  output cell_rsp_t        rsp_o
);
  logic [1:0]     st_q, st_d;
  logic [TxW-1:0] tx_q;
  logic           in_rng;

  assign in_rng = ({1'b0, idx_i} >= {1'b0, cmd_i.lo}) && ({1'b0, idx_i} < cmd_i.hi);

  // Response and next status
  always_comb begin
    rsp_o.is_free = (st_q == StFree);
    rsp_o.bad     = (st_q != StUsed);
    rsp_o.hit     = 1'b0;
    st_d          = st_q;
    unique case (cmd_i.op)
      ActAlloc: begin
        rsp_o.hit = in_rng;
        if (in_rng) st_d = StUsed;
      end
      ActFree: begin
        rsp_o.hit = in_rng;
        if (in_rng) st_d = StPend;
      end
      ActRelease: begin
        rsp_o.hit = (st_q == StPend) && (tx_q <= cmd_i.tx);
        if (rsp_o.hit) st_d = StFree;
      end
      ActRollback: begin
        rsp_o.hit = (st_q == StPend) && (tx_q == cmd_i.tx);
        if (rsp_o.hit) st_d = StUsed;
      end
      ActClear: begin
        if (st_q == StFree) st_d = StUsed;
      end
      ActLoad: begin
        rsp_o.hit = in_rng && (st_q == StUsed);
        if (rsp_o.hit) st_d = StFree;
      end
      ActResetAll: st_d = StUsed;
      default: st_d = st_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StUsed;
    end else if (en_i && cmd_i.apply) begin
      st_q <= st_d;
    end
  end

  // Transaction tag written when the page goes pending
  always_ff @(posedge clk_i) begin
    if (en_i && cmd_i.apply && cmd_i.op == ActFree && in_rng) begin
      tx_q <= cmd_i.tx;
    end
  end
endmodule

// ===== design/prfl_chain.sv =====
// Row of page cells; a token walks the row, one cell a cycle.
module prfl_chain
  import prfl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PageW-1:0] pos_i,
  input  cell_cmd_t        cmd_i,
  output cell_rsp_t        rsp_o
);
  cell_rsp_t rsp [NumPages];

  // Token handed from cell to cell as the scan position advances
  for (genvar g = 0; g < NumPages; g++) begin : g_cell
    prfl_cell u_cell (
      .clk_i,
      .rst_ni,
      .idx_i (PageW'(g)),
      .en_i  (pos_i == PageW'(g)),
      .cmd_i,
      .rsp_o (rsp[g])
    );
  end

  assign rsp_o = rsp[pos_i];
endmodule

// ===== design/page_run_free_list.sv =====
// Top level: page free list with a walking scan over a chain of page cells.
//  channel | dir | fields (tdata low bit up)                  | beat
//  s_axis  | in  | action[2:0] page_id[9:0] run_pages[10:0] tx_id[31:0] | one command
//  m_axis  | out | start_page[9:0] status[1:0] free_pages[10:0] pending_pages[10:0] | one result
// Release, rollback, clear and reset-all visit all NumPages cells, one a cycle. Allocate
// scans from page 2 until the run is found, then marks the run. Free checks then writes
// its run. Load writes its one page; a done state then posts the result.
// Reset puts all pages in use with zero counts. A result waits in the output register;
// the next command is taken once that result has been taken.
module page_run_free_list
  import prfl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // action, page_id, run_pages, tx_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // start_page, status, free_pages, pending_pages
);
  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SCheck = 2'd1;  // find / check pass
  localparam logic [1:0] SApply = 2'd2;  // commit pass
  localparam logic [1:0] SDone  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [2:0]       op_q;
  logic [PageW-1:0] pid_q;
  logic [PageW:0]   run_q;
  logic [TxW-1:0]   tx_q;
  logic [PageW-1:0] pos_q, pos_d;
  logic [PageW:0]   cnt_q, cnt_d;      // free run length so far
  logic [PageW-1:0] lo_q, lo_d;
  logic [PageW:0]   hi_q, hi_d;
  logic [1:0]       rs_q, rs_d;
  logic [CountW-1:0] free_q, free_d, pend_q, pend_d;
  logic [PageW-1:0] spage_q, spage_d;
  logic             outv_q;
  cell_cmd_t        cmd;
  cell_rsp_t        rsp;
  logic             take, last;
  logic [PageW+1:0] endp;

  assign take          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == SIdle) && !outv_q;
  assign last          = (pos_q == PageW'(NumPages - 1));
  assign endp          = {2'b0, pid_q} + {1'b0, run_q};

  assign cmd.op    = op_q;
  assign cmd.lo    = lo_q;
  assign cmd.hi    = hi_q;
  assign cmd.tx    = tx_q;
  assign cmd.apply = (state_q == SApply);

  prfl_chain u_chain (
    .clk_i,
    .rst_ni,
    .pos_i (pos_q),
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  // Scan sequencer
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    rs_d    = rs_q;
    free_d  = free_q;
    pend_d  = pend_q;
    spage_d = spage_q;
    unique case (state_q)
      SIdle: begin
        if (take) begin
          rs_d    = RsOk;
          spage_d = '0;
          cnt_d   = '0;
          pos_d   = '0;
          lo_d    = s_axis_tdata[12:3];
          hi_d    = {1'b0, s_axis_tdata[12:3]} + 1'b1;
          state_d = SApply;
          priority case (s_axis_tdata[2:0])
            ActAlloc: begin
              pos_d = PageW'(2);
              if (s_axis_tdata[23:13] == '0 ||
                  {1'b0, s_axis_tdata[23:13]} > (PageW+2)'(NumPages)) begin
                rs_d = RsNoRun; state_d = SDone;
              end else state_d = SCheck;
            end
            ActFree, ActLoad: begin
              pos_d = s_axis_tdata[12:3];
              if (s_axis_tdata[12:3] < PageW'(2)) begin
                rs_d = RsLowPage; state_d = SDone;
              end else if (s_axis_tdata[2:0] == ActFree) begin
                if (s_axis_tdata[23:13] == '0) state_d = SDone;
                else state_d = SCheck;
              end
            end
            default: begin
              if (s_axis_tdata[2:0] == ActUnused) state_d = SDone;
            end
          endcase
        end
      end
      SCheck: begin
        if (op_q == ActAlloc) begin
          cnt_d = rsp.is_free ? cnt_q + 1'b1 : '0;
          if (rsp.is_free && cnt_q + 1'b1 == run_q) begin
            lo_d    = pos_q - PageW'(run_q - 1'b1);
            hi_d    = {1'b0, pos_q} + 1'b1;
            pos_d   = pos_q - PageW'(run_q - 1'b1);
            spage_d = pos_q - PageW'(run_q - 1'b1);
            free_d  = free_q - CountW'(run_q);
            state_d = SApply;
          end else if (last) begin
            rs_d = RsNoRun; state_d = SDone;
          end else pos_d = pos_q + 1'b1;
        end else begin
          // free: walk run, checking pages in use
          if (rsp.bad) begin
            rs_d = RsDouble; state_d = SDone;
          end else if (last || {2'b0, pos_q} + 1'b1 >= endp) begin
            lo_d    = pid_q;
            hi_d    = (endp > (PageW+2)'(NumPages)) ? (PageW+1)'(NumPages)
                                                    : endp[PageW:0];
            pos_d   = pid_q;
            state_d = SApply;
          end else pos_d = pos_q + 1'b1;
        end
      end
      SApply: begin
        if (op_q == ActFree) pend_d = pend_q + 1'b1;
        if (op_q == ActRelease && rsp.hit) begin
          pend_d = pend_q - 1'b1; free_d = free_q + 1'b1;
        end
        if (op_q == ActRollback && rsp.hit) pend_d = pend_q - 1'b1;
        if (op_q == ActLoad && rsp.hit) free_d = free_q + 1'b1;
        if (op_q == ActClear) free_d = '0;
        if (op_q == ActResetAll) begin
          free_d = '0; pend_d = '0;
        end
        if (op_q == ActLoad) state_d = SDone;
        else if (op_q == ActAlloc || op_q == ActFree) begin
          if ({1'b0, pos_q} + 1'b1 >= hi_q) state_d = SDone;
          else pos_d = pos_q + 1'b1;
        end else if (last) state_d = SDone;
        else pos_d = pos_q + 1'b1;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      outv_q  <= 1'b0;
      free_q  <= '0;
      pend_q  <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      if (state_q == SDone) outv_q <= 1'b1;
      else if (m_axis_tready) outv_q <= 1'b0;
    end
  end

  // Command and scan payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= s_axis_tdata[2:0];
      pid_q <= s_axis_tdata[12:3];
      run_q <= s_axis_tdata[23:13];
      tx_q  <= s_axis_tdata[55:24];
    end
    cnt_q   <= cnt_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    rs_q    <= rs_d;
    spage_q <= spage_d;
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = {6'b0, pend_q, free_q, rs_q, spage_q};

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == SIdle)) else $error("ready outside idle");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(outv_q) |-> $past(state_q) == SDone) else $error("result without done");
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q + pend_q) <= CountW'(NumPages)) else $error("count overflow");
`endif
endmodule

// ===== bench/tb_page_run_free_list.sv =====
// Testbench for page_run_free_list: directed, random and backpressure tests.
module tb_page_run_free_list;
  import prfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Fields from the top bit down, so start_page lands in the low bits
  typedef struct packed {
    logic [CountW-1:0] pending_pages;
    logic [CountW-1:0] free_pages;
    logic [1:0]        status;
    logic [PageW-1:0]  start_page;
  } page_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // action, page_id, run_pages, tx_id
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // start_page, status, free_pages, pending_pages

  page_run_free_list dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [1:0]     pg_state [NumPages];
  logic [TxW-1:0] pg_tx    [NumPages];
  int unsigned    free_cnt, pend_cnt;
  page_result_t   expected_q[$];

  int unsigned send_idle_pct, recv_idle_pct, recv_hold;
  int unsigned n_items, n_results, n_errors;

  function automatic void clear_pages();
    for (int i = 0; i < NumPages; i++) pg_state[i] = StUsed;
    free_cnt = 0;
    pend_cnt = 0;
  endfunction

  // Apply one command to the page table and return the result it should give.
  function automatic page_result_t predict_page_op(logic [2:0] act, int unsigned pid,
                                                   int unsigned runp, logic [TxW-1:0] tx);
    page_result_t r;
    int unsigned  run, first;
    bit           bad;
    r = '0;
    case (act)
      ActAlloc: begin
        r.status = RsNoRun;
        run = 0;
        if (runp != 0 && runp <= NumPages) begin
          for (int i = 2; i < NumPages; i++) begin
            run = (pg_state[i] == StFree) ? run + 1 : 0;
            if (run == runp) begin
              first = i + 1 - runp;
              for (int k = first; k <= i; k++) pg_state[k] = StUsed;
              free_cnt -= runp;
              r.start_page = PageW'(first);
              r.status = RsOk;
              break;
            end
          end
        end
      end
      ActFree: begin
        bad = 0;
        if (pid < 2) r.status = RsLowPage;
        else begin
          for (int k = pid; k < pid + runp && k < NumPages; k++)
            if (pg_state[k] != StUsed) bad = 1;
          if (bad) r.status = RsDouble;
          else begin
            for (int k = pid; k < pid + runp && k < NumPages; k++) begin
              pg_state[k] = StPend;
              pg_tx[k] = tx;
              pend_cnt++;
            end
          end
        end
      end
      ActRelease:
        for (int i = 0; i < NumPages; i++)
          if (pg_state[i] == StPend && pg_tx[i] <= tx) begin
            pg_state[i] = StFree;
            pend_cnt--;
            free_cnt++;
          end
      ActRollback:
        for (int i = 0; i < NumPages; i++)
          if (pg_state[i] == StPend && pg_tx[i] == tx) begin
            pg_state[i] = StUsed;
            pend_cnt--;
          end
      ActClear: begin
        for (int i = 0; i < NumPages; i++)
          if (pg_state[i] == StFree) pg_state[i] = StUsed;
        free_cnt = 0;
      end
      ActLoad:
        if (pid < 2) r.status = RsLowPage;
        else if (pg_state[pid] == StUsed) begin
          pg_state[pid] = StFree;
          free_cnt++;
        end
      ActResetAll: clear_pages();
      default: ;
    endcase
    r.free_pages = CountW'(free_cnt);
    r.pending_pages = CountW'(pend_cnt);
    return r;
  endfunction

  // Offer one command beat; predict once it is taken.
  task automatic send_cmd(logic [2:0] act, int unsigned pid, int unsigned runp,
                          logic [TxW-1:0] tx);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tx, runp[10:0], pid[9:0], act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q = {expected_q, predict_page_op(act, pid, runp, tx)};
    n_items++;
  endtask

  // Receiver readiness: random idling, or a long hold when asked
  always @(posedge clk_i) begin
    if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    page_result_t got, exp;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[33:0];
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        n_errors++;
      end else begin
        exp = expected_q.pop_front();
        if (got.start_page !== exp.start_page) begin
          $error("start_page expected %0d got %0d", exp.start_page, got.start_page);
          n_errors++;
        end
        if (got.status !== exp.status) begin
          $error("status expected %0d got %0d", exp.status, got.status);
          n_errors++;
        end
        if (got.free_pages !== exp.free_pages) begin
          $error("free_pages expected %0d got %0d", exp.free_pages, got.free_pages);
          n_errors++;
        end
        if (got.pending_pages !== exp.pending_pages) begin
          $error("pending_pages expected %0d got %0d", exp.pending_pages,
                 got.pending_pages);
          n_errors++;
        end
      end
    end
  end

  // Edge cases named in the spec, in an order that builds on earlier state
  task automatic test_directed();
    send_cmd(ActAlloc, 0, 0, 0);              // zero-page allocate
    send_cmd(ActAlloc, 1023, 2047, 0);        // more pages than exist
    send_cmd(ActAlloc, 0, 1, 0);              // nothing free yet
    send_cmd(ActLoad, 0, 0, 0);               // reserved pages
    send_cmd(ActLoad, 1, 0, 0);
    send_cmd(ActLoad, 1023, 0, 0);
    send_cmd(ActLoad, 1023, 0, 0);            // already free
    send_cmd(ActFree, 1010, 20, 5);           // run overlaps a free page
    send_cmd(ActClear, 0, 0, 0);
    send_cmd(ActFree, 1010, 1024, 5);         // run past the last page
    send_cmd(ActLoad, 1015, 0, 0);            // pending page: no change
    send_cmd(ActFree, 2, 0, 7);               // empty run
    send_cmd(ActFree, 2, 8, 32'hFFFF_FFFF);
    send_cmd(ActFree, 2, 1, 1);               // double free of pending page
    send_cmd(ActRollback, 0, 0, 5);
    send_cmd(ActRelease, 0, 0, 32'hFFFF_FFFF);
    send_cmd(ActAlloc, 0, 3, 0);
    send_cmd(ActAlloc, 0, 1024, 0);
    send_cmd(ActFree, 1, 1, 0);               // page below 2
    send_cmd(ActUnused, 1023, 2047, 32'hFFFF_FFFF); // unused action
    send_cmd(ActResetAll, 0, 0, 0);
    send_cmd(ActFree, 500, 2047, 0);
    send_cmd(ActRelease, 0, 0, 0);
    send_cmd(ActAlloc, 0, 524, 0);
    send_cmd(ActAlloc, 0, 1, 0);
  endtask

  // Weighted random mix that keeps pages cycling through all three states
  task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    int unsigned    sel, pid, runp;
    logic [TxW-1:0] tx;
    logic [2:0]     act;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      sel  = $urandom_range(99);
      pid  = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(1023, 2);
      runp = ($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(12, 1);
      tx   = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(15);
      if (sel < 32)      act = ActLoad;
      else if (sel < 54) act = ActFree;
      else if (sel < 74) act = ActAlloc;
      else if (sel < 85) act = ActRelease;
      else if (sel < 93) act = ActRollback;
      else if (sel < 96) act = ActClear;
      else if (sel < 98) act = ActResetAll;
      else               act = ActUnused;
      send_cmd(act, pid, runp, tx);
    end
  endtask

  // Long receiver hold while commands keep coming, so the block stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 400;
    for (int i = 0; i < 6; i++) send_cmd(ActLoad, $urandom_range(1023, 2), 0, 0);
    send_cmd(ActAlloc, 0, 2, 0);
  endtask

  initial begin
    recv_hold = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clear_pages();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(185, 27, 46);
    test_backpressure();
    test_random(185, 46, 27);
    test_random(185, 0, 0);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    $display("Ran %0d commands over all actions and edge pages, checked %0d results.",
             n_items, n_results);
    $display("Idle patterns on both sides plus one long output stall were covered.");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end
endmodule
